// ===== hdl/afm_pkg.sv =====
// Shared types and constants of the flag-setting ALU and multiply unit.
// Holds the operation codes, the request and result layouts and the
// stage payload passed from the multiplier to the execute logic.
package afm_pkg;

    typedef enum logic [4:0] {
        ACT_AND   = 5'd0,
        ACT_EOR   = 5'd1,
        ACT_SUB   = 5'd2,
        ACT_RSB   = 5'd3,
        ACT_ADD   = 5'd4,
        ACT_ADC   = 5'd5,
        ACT_SBC   = 5'd6,
        ACT_RSC   = 5'd7,
        ACT_TST   = 5'd8,
        ACT_TEQ   = 5'd9,
        ACT_CMP   = 5'd10,
        ACT_CMN   = 5'd11,
        ACT_MOV   = 5'd12,
        ACT_MVN   = 5'd13,
        ACT_MUL   = 5'd14,
        ACT_MLA   = 5'd15,
        ACT_UMULL = 5'd16,
        ACT_UMLAL = 5'd17,
        ACT_SMULL = 5'd18,
        ACT_SMLAL = 5'd19
    } t_action;

    // flag bit positions in NZCV
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    localparam int IN_BITS    = 137;
    localparam int IN_TDATA_W = 144;
    localparam int OUT_TDATA_W = 72;

    typedef logic [3:0] t_flags;

    // last field in the lowest bits
    typedef struct packed {
        logic        long_names_pc;
        logic [31:0] accum_high;
        logic [31:0] accum_low;
        logic        dest_is_pc;
        logic        set_flags;
        logic        shifter_carry;
        logic [31:0] second_operand;
        logic [31:0] first_operand;
        t_action     action;
    } t_in_item;

    typedef struct packed {
        t_flags      flags_out;
        logic        exception_return;
        logic        pc_write;
        logic        write_high;
        logic        write_low;
        logic [31:0] result_high;
        logic [31:0] result_low;
    } t_out_item;

    // payload between the multiply stage and the execute stage
    typedef struct packed {
        t_action     action;
        logic [31:0] op_a;
        logic [31:0] op_b;
        logic        shifter_carry;
        logic        set_flags;
        logic        dest_is_pc;
        logic        long_names_pc;
        logic [63:0] product;
        logic [63:0] addend;
    } t_mul_stage;

endpackage

// ===== hdl/afm_mult.sv =====
// Multiply stage: registered 32x32 unsigned product and the 64-bit addend
// with the signed-product correction folded into its high word. Uses afm_pkg.
module afm_mult (
    input  logic                i_clk,
    input  logic                i_en,
    input  afm_pkg::t_in_item   i_item,
    output afm_pkg::t_mul_stage o_stage
);
    import afm_pkg::*;

    t_mul_stage  r_stage;
    t_mul_stage  n_stage;
    logic [31:0] corr;

    always_comb begin
        corr = (i_item.first_operand[31]  ? i_item.second_operand : 32'd0)
             + (i_item.second_operand[31] ? i_item.first_operand  : 32'd0);

        n_stage.action        = i_item.action;
        n_stage.op_a          = i_item.first_operand;
        n_stage.op_b          = i_item.second_operand;
        n_stage.shifter_carry = i_item.shifter_carry;
        n_stage.set_flags     = i_item.set_flags;
        n_stage.dest_is_pc    = i_item.dest_is_pc;
        n_stage.long_names_pc = i_item.long_names_pc;
        n_stage.product       = 64'(i_item.first_operand) * 64'(i_item.second_operand);

        case (i_item.action)
            ACT_MLA:   n_stage.addend = {32'd0, i_item.accum_low};
            ACT_UMLAL: n_stage.addend = {i_item.accum_high, i_item.accum_low};
            ACT_SMULL: n_stage.addend = {32'd0 - corr, 32'd0};
            ACT_SMLAL: n_stage.addend = {i_item.accum_high - corr, i_item.accum_low};
            default:   n_stage.addend = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== hdl/afm_exec.sv =====
// Execute logic: logical unit, 32-bit adder, product accumulate, flag
// selection and program-counter handling for one request. Uses afm_pkg.
module afm_exec (
    input  afm_pkg::t_mul_stage i_stage,
    input  afm_pkg::t_flags     i_flags,
    output afm_pkg::t_out_item  o_result,
    output afm_pkg::t_flags     o_flags
);
    import afm_pkg::*;

    logic [31:0] logic_r;
    logic [31:0] add_x;
    logic [31:0] add_y;
    logic        add_cin;
    logic [32:0] sum;
    t_flags      add_f;
    t_flags      logic_f;
    logic [63:0] p;
    logic [31:0] res;
    logic [31:0] rhi;
    logic        wl;
    logic        wh;
    logic        pw;
    logic        er;
    logic        dp;
    t_flags      nf;
    t_flags      dpf;

    always_comb begin
        case (i_stage.action)
            ACT_AND, ACT_TST: logic_r = i_stage.op_a & i_stage.op_b;
            ACT_EOR, ACT_TEQ: logic_r = i_stage.op_a ^ i_stage.op_b;
            ACT_MOV:          logic_r = i_stage.op_b;
            default:          logic_r = ~i_stage.op_b;
        endcase

        case (i_stage.action)
            ACT_SUB, ACT_CMP: begin
                add_x = i_stage.op_a; add_y = ~i_stage.op_b; add_cin = 1'b1;
            end
            ACT_RSB: begin
                add_x = i_stage.op_b; add_y = ~i_stage.op_a; add_cin = 1'b1;
            end
            ACT_ADC: begin
                add_x = i_stage.op_a; add_y = i_stage.op_b; add_cin = i_flags[FLAG_C];
            end
            ACT_SBC: begin
                add_x = i_stage.op_a; add_y = ~i_stage.op_b; add_cin = i_flags[FLAG_C];
            end
            ACT_RSC: begin
                add_x = i_stage.op_b; add_y = ~i_stage.op_a; add_cin = i_flags[FLAG_C];
            end
            default: begin
                add_x = i_stage.op_a; add_y = i_stage.op_b; add_cin = 1'b0;
            end
        endcase

        sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
        add_f = {sum[31], sum[31:0] == 32'd0, sum[32],
                 ~(add_x[31] ^ add_y[31]) & (add_x[31] ^ sum[31])};
        logic_f = {logic_r[31], logic_r == 32'd0, i_stage.shifter_carry, i_flags[FLAG_V]};

        p = i_stage.product + i_stage.addend;

        res = 32'd0;
        rhi = 32'd0;
        wl  = 1'b0;
        wh  = 1'b0;
        pw  = 1'b0;
        er  = 1'b0;
        dp  = 1'b0;
        nf  = i_flags;
        dpf = i_flags;

        case (i_stage.action)
            ACT_AND, ACT_EOR, ACT_MOV, ACT_MVN: begin
                res = logic_r;
                dpf = logic_f;
                dp  = 1'b1;
            end
            ACT_SUB, ACT_RSB, ACT_ADD, ACT_ADC, ACT_SBC, ACT_RSC: begin
                res = sum[31:0];
                dpf = add_f;
                dp  = 1'b1;
            end
            ACT_TST, ACT_TEQ: nf = logic_f;
            ACT_CMP, ACT_CMN: nf = add_f;
            ACT_MUL, ACT_MLA: begin
                res = p[31:0];
                wl  = 1'b1;
                if (i_stage.set_flags) begin
                    nf = {p[31], p[31:0] == 32'd0, i_flags[FLAG_C], i_flags[FLAG_V]};
                end
            end
            ACT_UMULL, ACT_UMLAL, ACT_SMULL, ACT_SMLAL: begin
                if (!i_stage.long_names_pc) begin
                    res = p[31:0];
                    rhi = p[63:32];
                    wl  = 1'b1;
                    wh  = 1'b1;
                    if (i_stage.set_flags) begin
                        nf = {p[63], p == 64'd0, i_flags[FLAG_C], i_flags[FLAG_V]};
                    end
                end
            end
            default: ;
        endcase

        if (dp) begin
            if (i_stage.dest_is_pc) begin
                if (i_stage.set_flags) begin
                    er = 1'b1;
                end else begin
                    res = {res[31:2], 2'b00};
                    pw  = 1'b1;
                end
            end else begin
                wl = 1'b1;
                if (i_stage.set_flags) begin
                    nf = dpf;
                end
            end
        end

        o_result.result_low       = res;
        o_result.result_high      = rhi;
        o_result.write_low        = wl;
        o_result.write_high       = wh;
        o_result.pc_write         = pw;
        o_result.exception_return = er;
        o_result.flags_out        = nf;
        o_flags                   = nf;
    end

endmodule

// ===== hdl/alu_flags_multiply_unit.sv =====
// Integer execute unit with NZCV flags: data-processing and multiply requests.
// Top level; instantiates afm_mult and afm_exec, uses afm_pkg.
//
// Usage:
//   Requests enter on the slave stream (i_s_tvalid/o_s_tready/i_s_tdata) with
//   operands already read and shifted. One result per request leaves on the
//   master stream (o_m_tvalid/i_m_tready/o_m_tdata) in request order.
//   Pipeline: input register, multiply register, result register.
//   Throughput is one request per cycle while the receiver takes results; the
//   32x32 multiplier and the 64-bit accumulate adder each take one stage, and
//   the flags are read and written in the last stage, so a carry is seen by
//   the very next request.
//   Reset clears the flags and empties all three stages.
//   When the receiver stalls, the result register holds and each stage keeps
//   accepting until it is full; o_s_tready falls only when all three are full.
module alu_flags_multiply_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // action, first_operand, second_operand, shifter_carry, set_flags,
    // dest_is_pc, accum_low, accum_high, long_names_pc; zero pad to 144
    input  logic [afm_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // result_low, result_high, write_low, write_high, pc_write,
    // exception_return, flags_out
    output logic [afm_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import afm_pkg::*;

    logic       r_v1;
    logic       r_v2;
    logic       r_v3;
    t_in_item   r_item;
    t_out_item  r_out;
    t_flags     r_flags;
    t_mul_stage stage2;
    t_out_item  exec_res;
    t_flags     n_flags;
    logic       adv1;
    logic       adv2;
    logic       adv3;

    assign adv3 = !r_v3 || i_m_tready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign o_s_tready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_flags <= '0;
        end else begin
            if (adv1) begin
                r_v1 <= i_s_tvalid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (adv3 && r_v2) begin
                r_flags <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_s_tvalid) begin
            r_item <= t_in_item'(i_s_tdata[IN_BITS-1:0]);
        end
        if (adv3 && r_v2) begin
            r_out <= exec_res;
        end
    end

    afm_mult u_mult (
        .i_clk   (i_clk),
        .i_en    (adv2 && r_v1),
        .i_item  (r_item),
        .o_stage (stage2)
    );

    afm_exec u_exec (
        .i_stage  (stage2),
        .i_flags  (r_flags),
        .o_result (exec_res),
        .o_flags  (n_flags)
    );

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = r_out;

    a_high_needs_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_out.write_high |-> r_out.write_low)
        else $error("high word written without low word");

    a_pc_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_out.pc_write |-> r_out.result_low[1:0] == 2'b00
                                   && !r_out.exception_return && !r_out.write_low)
        else $error("bad branch target result");

    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_v2 && adv3) |=> $stable(r_flags))
        else $error("flags changed without a request");

    a_flags_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> r_out.flags_out == r_flags)
        else $error("reported flags differ from stored flags");

endmodule

// ===== dv/tb_alu_flags_multiply_unit.sv =====
// Testbench for alu_flags_multiply_unit: directed table, then random requests
// with random stalls on both streams, checked against an in-bench NZCV predictor.
// Depends on afm_pkg (hdl/afm_pkg.sv) and the RTL top level.
module tb_alu_flags_multiply_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import afm_pkg::*;

    localparam int     RAND_REQS  = 1800;
    localparam int     CYCLE_CAP  = 400000;
    localparam int     MAX_PRINTS = 40;
    localparam t_action ACT_SPARE_LO = t_action'(5'd20);
    localparam t_action ACT_SPARE_HI = t_action'(5'd31);

    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    t_flags    nzcv_model;
    t_out_item pending_results[$];
    t_dir_row  dir_rows[$];
    t_out_item got, want;
    bit        calm = 1'b0;
    int        errors = 0;
    int        cycles = 0;
    int        n_requests = 0;
    int        n_results = 0;
    int        n_mult = 0;
    int        n_pc = 0;

    alu_flags_multiply_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("[alu_flags_multiply_unit] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] wanted);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch on result %0d, %s: got %0h want %0h",
                     n_results, what, seen, wanted);
    endtask

    // {flags, sum} of a + b + cin
    function automatic logic [35:0] add_nzcv(logic [31:0] a, logic [31:0] b, logic cin);
        logic [32:0] wide;
        t_flags      f;
        wide = {1'b0, a} + {1'b0, b} + 33'(cin);
        f[FLAG_N] = wide[31];
        f[FLAG_Z] = (wide[31:0] == 32'd0);
        f[FLAG_C] = wide[32];
        f[FLAG_V] = ~(a[31] ^ b[31]) & (a[31] ^ wide[31]);
        return {f, wide[31:0]};
    endfunction

    // one request through the execute unit; updates nzcv_model
    function automatic t_out_item execute_op(t_in_item q);
        t_out_item   o;
        t_flags      nf;
        logic [31:0] r;
        logic [63:0] p;
        logic        dp;
        o  = '0;
        nf = nzcv_model;
        r  = '0;
        dp = 1'b0;
        case (q.action)
            ACT_AND, ACT_EOR, ACT_MOV, ACT_MVN: begin
                case (q.action)
                    ACT_AND: r = q.first_operand & q.second_operand;
                    ACT_EOR: r = q.first_operand ^ q.second_operand;
                    ACT_MOV: r = q.second_operand;
                    default: r = ~q.second_operand;
                endcase
                nf = {r[31], r == 32'd0, q.shifter_carry, nzcv_model[FLAG_V]};
                dp = 1'b1;
            end
            ACT_SUB: begin
                {nf, r} = add_nzcv(q.first_operand, ~q.second_operand, 1'b1);
                dp = 1'b1;
            end
            ACT_RSB: begin
                {nf, r} = add_nzcv(q.second_operand, ~q.first_operand, 1'b1);
                dp = 1'b1;
            end
            ACT_ADD: begin
                {nf, r} = add_nzcv(q.first_operand, q.second_operand, 1'b0);
                dp = 1'b1;
            end
            ACT_ADC: begin
                {nf, r} = add_nzcv(q.first_operand, q.second_operand, nzcv_model[FLAG_C]);
                dp = 1'b1;
            end
            ACT_SBC: begin
                {nf, r} = add_nzcv(q.first_operand, ~q.second_operand, nzcv_model[FLAG_C]);
                dp = 1'b1;
            end
            ACT_RSC: begin
                {nf, r} = add_nzcv(q.second_operand, ~q.first_operand, nzcv_model[FLAG_C]);
                dp = 1'b1;
            end
            ACT_TST, ACT_TEQ: begin
                r = (q.action == ACT_TST) ? (q.first_operand & q.second_operand)
                                          : (q.first_operand ^ q.second_operand);
                nzcv_model = {r[31], r == 32'd0, q.shifter_carry, nzcv_model[FLAG_V]};
            end
            ACT_CMP: {nzcv_model, r} = add_nzcv(q.first_operand, ~q.second_operand, 1'b1);
            ACT_CMN: {nzcv_model, r} = add_nzcv(q.first_operand, q.second_operand, 1'b0);
            ACT_MUL, ACT_MLA: begin
                r = q.first_operand * q.second_operand
                    + ((q.action == ACT_MLA) ? q.accum_low : 32'd0);
                o.result_low = r;
                o.write_low  = 1'b1;
                if (q.set_flags)
                    nzcv_model = {r[31], r == 32'd0, nzcv_model[FLAG_C], nzcv_model[FLAG_V]};
            end
            ACT_UMULL, ACT_UMLAL, ACT_SMULL, ACT_SMLAL: begin
                if (!q.long_names_pc) begin
                    if (q.action == ACT_SMULL || q.action == ACT_SMLAL)
                        p = $signed(q.first_operand) * $signed(q.second_operand);
                    else
                        p = {32'd0, q.first_operand} * {32'd0, q.second_operand};
                    if (q.action == ACT_UMLAL || q.action == ACT_SMLAL)
                        p = p + {q.accum_high, q.accum_low};
                    o.result_low  = p[31:0];
                    o.result_high = p[63:32];
                    o.write_low   = 1'b1;
                    o.write_high  = 1'b1;
                    if (q.set_flags)
                        nzcv_model = {p[63], p == 64'd0, nzcv_model[FLAG_C], nzcv_model[FLAG_V]};
                end
            end
            default: ;
        endcase
        if (dp) begin
            if (q.dest_is_pc) begin
                if (q.set_flags) begin
                    o.exception_return = 1'b1;
                end else begin
                    r = r & ~32'd3;
                    o.pc_write = 1'b1;
                end
            end else begin
                o.write_low = 1'b1;
                if (q.set_flags)
                    nzcv_model = nf;
            end
            o.result_low = r;
        end
        o.flags_out = nzcv_model;
        return o;
    endfunction

    function automatic t_in_item make_req(t_action act, logic [31:0] a, logic [31:0] b,
                                          logic shc, logic s, logic pcd,
                                          logic [31:0] lo, logic [31:0] hi, logic lpc);
        t_in_item q;
        q.action         = act;
        q.first_operand  = a;
        q.second_operand = b;
        q.shifter_carry  = shc;
        q.set_flags      = s;
        q.dest_is_pc     = pcd;
        q.accum_low      = lo;
        q.accum_high     = hi;
        q.long_names_pc  = lpc;
        return q;
    endfunction

    // plain register write of a data-processing op
    function automatic t_out_item dp_result(logic [31:0] lo, t_flags f);
        t_out_item o;
        o = '0;
        o.result_low = lo;
        o.write_low  = 1'b1;
        o.flags_out  = f;
        return o;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item random_req();
        t_action act;
        if ($urandom_range(0, 39) == 0)
            act = t_action'(5'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)));
        else
            act = t_action'(5'($urandom_range(ACT_AND, ACT_SMLAL)));
        return make_req(act, pick_operand(), pick_operand(), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
                        pick_operand(), pick_operand(), $urandom_range(0, 7) == 0);
    endfunction

    task automatic send_request(t_in_item q);
        i_s_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, q};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        n_requests++;
        if (q.action inside {[ACT_MUL:ACT_SMLAL]})
            n_mult++;
        if (q.dest_is_pc || q.long_names_pc)
            n_pc++;
    endtask

    task automatic sender_gap();
        if (!calm)
            while ($urandom_range(0, 2) == 0) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = t_out_item'(o_m_tdata);
                n_results++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", got.result_low, 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.result_low != want.result_low)
                        report_mismatch("result_low", got.result_low, want.result_low);
                    if (got.result_high != want.result_high)
                        report_mismatch("result_high", got.result_high, want.result_high);
                    if (got.write_low != want.write_low)
                        report_mismatch("write_low", got.write_low, want.write_low);
                    if (got.write_high != want.write_high)
                        report_mismatch("write_high", got.write_high, want.write_high);
                    if (got.pc_write != want.pc_write)
                        report_mismatch("pc_write", got.pc_write, want.pc_write);
                    if (got.exception_return != want.exception_return)
                        report_mismatch("exception_return", got.exception_return,
                                        want.exception_return);
                    if (got.flags_out != want.flags_out)
                        report_mismatch("flags_out", got.flags_out, want.flags_out);
                end
            end
            i_m_tready <= calm || ($urandom_range(0, 2) != 0);
        end
    end

    initial begin
        t_out_item exp_res;
        nzcv_model = '0;

        // typed rows chain from reset flags
        dir_rows.push_back('{make_req(ACT_MOV, 32'd0, 32'd0, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0),
                             1'b1, dp_result(32'd0, 4'b0100)});
        dir_rows.push_back('{make_req(ACT_ADD, 32'hFFFF_FFFF, 32'd1, 1'b0, 1'b1, 1'b0,
                                      32'd0, 32'd0, 1'b0),
                             1'b1, dp_result(32'd0, 4'b0110)});
        dir_rows.push_back('{make_req(ACT_ADC, 32'h7FFF_FFFF, 32'd0, 1'b0, 1'b1, 1'b0,
                                      32'd0, 32'd0, 1'b0),
                             1'b1, dp_result(32'h8000_0000, 4'b1001)});
        dir_rows.push_back('{make_req(ACT_SUB, 32'h8000_0000, 32'd1, 1'b0, 1'b1, 1'b0,
                                      32'd0, 32'd0, 1'b0),
                             1'b1, dp_result(32'h7FFF_FFFF, 4'b0011)});
        dir_rows.push_back('{make_req(ACT_SBC, 32'd0, 32'd0, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0),
                             1'b1, dp_result(32'd0, 4'b0110)});
        dir_rows.push_back('{make_req(ACT_RSC, 32'd1, 32'd0, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0),
                             1'b0, '0});
        dir_rows.push_back('{make_req(ACT_RSB, 32'd5, 32'd3, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0),
                             1'b0, '0});
        dir_rows.push_back('{make_req(ACT_AND, 32'hFFFF_FFFF, 32'h1234_5677, 1'b1, 1'b0, 1'b1,
                                      32'd0, 32'd0, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_req(ACT_EOR, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1, 1'b1,
                                      32'd0, 32'd0, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_req(ACT_MOV, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1,
                                      32'd0, 32'd0, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_req(ACT_TST, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1,
                                      32'd0, 32'd0, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_req(ACT_TEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0,
                                      32'd0, 32'd0, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_req(ACT_CMP, 32'd0, 32'd1, 1'b0, 1'b0, 1'b1, 32'd0, 32'd0, 1'b0),
                             1'b0, '0});
        dir_rows.push_back('{make_req(ACT_CMN, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 1'b0,
                                      32'd0, 32'd0, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_req(ACT_MVN, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0),
                             1'b0, '0});
        dir_rows.push_back('{make_req(ACT_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1,
                                      32'd0, 32'd0, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_req(ACT_MLA, 32'd0, 32'h1234_5678, 1'b0, 1'b1, 1'b0,
                                      32'd0, 32'd0, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_req(ACT_UMULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_req(ACT_UMLAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_req(ACT_SMULL, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1, 1'b0,
                                      32'd0, 32'd0, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_req(ACT_SMLAL, 32'hFFFF_FFFF, 32'd1, 1'b0, 1'b1, 1'b0,
                                      32'd0, 32'd0, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_req(ACT_SMULL, 32'd7, 32'd9, 1'b0, 1'b1, 1'b0,
                                      32'd0, 32'd0, 1'b1), 1'b0, '0});
        dir_rows.push_back('{make_req(ACT_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 1'b0, '0});
        dir_rows.push_back('{make_req(ACT_SPARE_HI, 32'd1, 32'd2, 1'b0, 1'b1, 1'b0,
                                      32'd3, 32'd4, 1'b0), 1'b0, '0});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_request(dir_rows[k].req);
            exp_res = execute_op(dir_rows[k].req);
            pending_results.push_back(dir_rows[k].typed ? dir_rows[k].want : exp_res);
            sender_gap();
        end
        drain_results();

        for (int k = 0; k < RAND_REQS; k++) begin
            t_in_item q;
            calm = (k >= 600 && k < 900);
            if (k == 1200)
                drain_results();
            q = random_req();
            send_request(q);
            pending_results.push_back(execute_op(q));
            sender_gap();
        end
        calm = 1'b0;
        drain_results();
        repeat (10) @(posedge i_clk);

        $display("sent %0d requests (%0d multiplies, %0d naming r15), checked %0d results",
                 n_requests, n_mult, n_pc, n_results);
        $display("random stalls on both streams, one full drain mid-run, %0d mismatches",
                 errors);
        if (errors == 0)
            $display("[alu_flags_multiply_unit] OK");
        else
            $display("[alu_flags_multiply_unit] ERROR");
        $finish;
    end

endmodule
